// ===== rtl/triangle_face_adjacency_unit_assert.svh =====
// assertion macros for the triangle face adjacency unit
`ifndef TRIANGLE_FACE_ADJACENCY_UNIT_ASSERT_SVH
`define TRIANGLE_FACE_ADJACENCY_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define TFA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tfa assertion failed");
`define TFA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tfa assertion failed");
`else
`define TFA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TFA_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/tfa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tfa_pkg;

  localparam int MAX_FACES_DEF = 1024;
  localparam int IDX_W = 10;
  localparam int VTX_W = 16;
  localparam int CNT_W = 11;
  localparam int TRI_W = 3 * VTX_W;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic write;
    logic query_start;
    logic load;
    logic scan;
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic limit_zero;
    logic scan_last;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/triangle_face_adjacency_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// triangle face adjacency unit
// a transaction is taken at a rising edge with start_i high and busy_o low.
// mode_i = 0 stores vertex_a_i/b_i/c_i at slot face_index_i; it gives no
// result and leaves busy_o low.
// mode_i = 1 queries face_index_i: its triangle is read, then slots
// 0..min(face_count,MaxFaces)-1 are read one per cycle through the single
// face table port and compared; the last matching face wins per edge.
// a query passes through the load state, the scan state (left out when
// there is nothing to scan) and the result state before the next accept.
// a query on a slot outside the table goes from idle straight to result.
// the result is on the result ports for the single cycle in which done_o is
// high; the receiver cannot stall, so nothing waits on it.
// face_count is to be written via cfg_we_i/cfg_wdata_i while idle; the
// block does not enforce it. reset clears face_count and the controller;
// face table stays undefined until written; no clearing pass runs.
module triangle_face_adjacency_unit #(
  parameter int MaxFaces = tfa_pkg::MAX_FACES_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [tfa_pkg::CNT_W-1:0] cfg_wdata_i,
  input  wire logic                      start_i,
  output logic                           busy_o,
  input  wire logic                      mode_i,
  input  wire logic [tfa_pkg::IDX_W-1:0] face_index_i,
  input  wire logic [tfa_pkg::VTX_W-1:0] vertex_a_i,
  input  wire logic [tfa_pkg::VTX_W-1:0] vertex_b_i,
  input  wire logic [tfa_pkg::VTX_W-1:0] vertex_c_i,
  output logic                           done_o,
  output logic      [tfa_pkg::IDX_W-1:0] queried_face_o,
  output logic      [tfa_pkg::IDX_W-1:0] across_ab_o,
  output logic                           found_ab_o,
  output logic      [tfa_pkg::IDX_W-1:0] across_ac_o,
  output logic                           found_ac_o,
  output logic      [tfa_pkg::IDX_W-1:0] across_bc_o,
  output logic                           found_bc_o
);

  tfa_pkg::cmd_t  cmd;
  tfa_pkg::stat_t stat;

  tfa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .mode_i  (mode_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  tfa_datapath #(
    .MaxFaces (MaxFaces)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .face_index_i   (face_index_i),
    .vertex_a_i     (vertex_a_i),
    .vertex_b_i     (vertex_b_i),
    .vertex_c_i     (vertex_c_i),
    .queried_face_o (queried_face_o),
    .across_ab_o    (across_ab_o),
    .found_ab_o     (found_ab_o),
    .across_ac_o    (across_ac_o),
    .found_ac_o     (found_ac_o),
    .across_bc_o    (across_bc_o),
    .found_bc_o     (found_bc_o)
  );

`include "triangle_face_adjacency_unit_assert.svh"

  `TFA_ASSERT_NXT(a_done_single, clk_i, rst_ni, done_o, !done_o)
  `TFA_ASSERT_IMP(a_done_busy, clk_i, rst_ni, done_o, busy_o)
  `TFA_ASSERT_NXT(a_write_free, clk_i, rst_ni, cmd.write, !busy_o)
  `TFA_ASSERT_NXT(a_query_busy, clk_i, rst_ni, cmd.query_start, busy_o)
  `TFA_ASSERT_IMP(a_scan_excl, clk_i, rst_ni, cmd.scan, !cmd.load && !done_o)

endmodule
`default_nettype wire

// ===== rtl/tfa_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tfa_ram #(
  parameter int Width = 48,
  parameter int Depth = 1024,
  localparam int AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/tfa_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tfa_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic          mode_i,
  input  wire tfa_pkg::stat_t stat_i,
  output tfa_pkg::cmd_t      cmd_o,
  output logic               busy_o,
  output logic               done_o
);

  tfa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tfa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tfa_pkg::ST_IDLE: begin
        if (start_i && (mode_i == tfa_pkg::MODE_QUERY)) begin
          // a slot outside the table reports straight away
          state_d = stat_i.in_range ? tfa_pkg::ST_LOAD : tfa_pkg::ST_DONE;
        end
      end
      tfa_pkg::ST_LOAD: begin
        state_d = stat_i.limit_zero ? tfa_pkg::ST_DONE : tfa_pkg::ST_SCAN;
      end
      tfa_pkg::ST_SCAN: begin
        if (stat_i.scan_last) begin
          state_d = tfa_pkg::ST_DONE;
        end
      end
      tfa_pkg::ST_DONE: begin
        state_d = tfa_pkg::ST_IDLE;
      end
      default: begin
        state_d = tfa_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy_o = 1'b1;
    done_o = 1'b0;
    case (state_q)
      tfa_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        cmd_o.write = start_i && (mode_i == tfa_pkg::MODE_WRITE);
        cmd_o.query_start = start_i && (mode_i == tfa_pkg::MODE_QUERY);
      end
      tfa_pkg::ST_LOAD: begin
        cmd_o.load = 1'b1;
      end
      tfa_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      tfa_pkg::ST_DONE: begin
        done_o = 1'b1;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/tfa_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tfa_datapath #(
  parameter int MaxFaces = tfa_pkg::MAX_FACES_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [tfa_pkg::CNT_W-1:0]  cfg_wdata_i,
  input  wire tfa_pkg::cmd_t              cmd_i,
  output tfa_pkg::stat_t                  stat_o,
  input  wire logic [tfa_pkg::IDX_W-1:0]  face_index_i,
  input  wire logic [tfa_pkg::VTX_W-1:0]  vertex_a_i,
  input  wire logic [tfa_pkg::VTX_W-1:0]  vertex_b_i,
  input  wire logic [tfa_pkg::VTX_W-1:0]  vertex_c_i,
  output logic      [tfa_pkg::IDX_W-1:0]  queried_face_o,
  output logic      [tfa_pkg::IDX_W-1:0]  across_ab_o,
  output logic                            found_ab_o,
  output logic      [tfa_pkg::IDX_W-1:0]  across_ac_o,
  output logic                            found_ac_o,
  output logic      [tfa_pkg::IDX_W-1:0]  across_bc_o,
  output logic                            found_bc_o
);

  localparam int AddrW = $clog2(MaxFaces);
  localparam int CntW = $clog2(MaxFaces + 1);
  localparam int VW = tfa_pkg::VTX_W;

  logic [tfa_pkg::CNT_W-1:0] face_count_q;
  logic [CntW-1:0]           limit;
  logic [CntW-1:0]           j_q, j_d, j_nxt;
  logic [tfa_pkg::IDX_W-1:0] fi_q;
  logic [VW-1:0]             a_q, b_q, c_q;
  logic [tfa_pkg::IDX_W-1:0] ab_q, ac_q, bc_q;
  logic                      fab_q, fac_q, fbc_q;
  logic                      ram_we;
  logic [AddrW-1:0]          ram_addr;
  logic [tfa_pkg::TRI_W-1:0] ram_rdata;
  logic [VW-1:0]             p, q, r;
  logic                      hit_ab, hit_ac, hit_bc, in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      face_count_q <= '0;
    end else if (cfg_we_i) begin
      face_count_q <= cfg_wdata_i;
    end
  end

  // scan saturates at the table depth
  assign limit = (32'(face_count_q) > 32'(MaxFaces)) ? CntW'(MaxFaces)
                                                     : CntW'(face_count_q);
  assign in_range = 32'(face_index_i) < 32'(MaxFaces);
  assign j_nxt = j_q + CntW'(1);

  assign stat_o.in_range = in_range;
  assign stat_o.limit_zero = (limit == '0);
  assign stat_o.scan_last = (j_nxt == limit);

  always_comb begin
    ram_we = cmd_i.write && in_range;
    ram_addr = AddrW'(face_index_i);
    j_d = j_q;
    if (cmd_i.load) begin
      ram_addr = '0;
      j_d = '0;
    end else if (cmd_i.scan) begin
      ram_addr = AddrW'(j_nxt);
      j_d = j_nxt;
    end
  end

  tfa_ram #(
    .Width (tfa_pkg::TRI_W),
    .Depth (MaxFaces)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i ({vertex_a_i, vertex_b_i, vertex_c_i}),
    .rdata_o (ram_rdata)
  );

  assign p = ram_rdata[3*VW-1:2*VW];
  assign q = ram_rdata[2*VW-1:VW];
  assign r = ram_rdata[VW-1:0];

  always_comb begin
    logic [VW-1:0] o1, o2;
    logic          sh_a, sh_b;
    sh_a = 1'b1;
    sh_b = 1'b1;
    o1 = '0;
    o2 = '0;
    hit_ab = 1'b0;
    hit_ac = 1'b0;
    hit_bc = 1'b0;
    // first vertex equal to a is the shared one, then fall back to b
    if (p == a_q) begin
      o1 = q; o2 = r;
    end else if (q == a_q) begin
      o1 = p; o2 = r;
    end else if (r == a_q) begin
      o1 = p; o2 = q;
    end else begin
      sh_a = 1'b0;
    end
    if (sh_a) begin
      sh_b = 1'b0;
      if ((o1 == b_q) || (o2 == b_q)) begin
        hit_ab = 1'b1;
      end else if ((o1 == c_q) || (o2 == c_q)) begin
        hit_ac = 1'b1;
      end
    end else begin
      if (p == b_q) begin
        o1 = q; o2 = r;
      end else if (q == b_q) begin
        o1 = p; o2 = r;
      end else if (r == b_q) begin
        o1 = p; o2 = q;
      end else begin
        sh_b = 1'b0;
      end
      hit_bc = sh_b && ((o1 == c_q) || (o2 == c_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q <= '0;
    end else begin
      j_q <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.query_start) begin
      fi_q <= face_index_i;
      ab_q <= '0;
      ac_q <= '0;
      bc_q <= '0;
      fab_q <= 1'b0;
      fac_q <= 1'b0;
      fbc_q <= 1'b0;
    end
    if (cmd_i.load) begin
      a_q <= p;
      b_q <= q;
      c_q <= r;
    end
    // the queried face itself is skipped, later matches overwrite earlier
    if (cmd_i.scan && (32'(j_q) != 32'(fi_q))) begin
      if (hit_ab) begin
        ab_q <= tfa_pkg::IDX_W'(j_q);
        fab_q <= 1'b1;
      end
      if (hit_ac) begin
        ac_q <= tfa_pkg::IDX_W'(j_q);
        fac_q <= 1'b1;
      end
      if (hit_bc) begin
        bc_q <= tfa_pkg::IDX_W'(j_q);
        fbc_q <= 1'b1;
      end
    end
  end

  assign queried_face_o = fi_q;
  assign across_ab_o = ab_q;
  assign found_ab_o = fab_q;
  assign across_ac_o = ac_q;
  assign found_ac_o = fac_q;
  assign across_bc_o = bc_q;
  assign found_bc_o = fbc_q;

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import tfa_pkg::*;

  localparam int QUIET_LIMIT = 8 * (MAX_FACES_DEF + 8);

  typedef struct packed {
    logic [IDX_W-1:0] face;
    logic [IDX_W-1:0] ab;
    logic             fab;
    logic [IDX_W-1:0] ac;
    logic             fac;
    logic [IDX_W-1:0] bc;
    logic             fbc;
  } adjacency_t;

  class neighbour_tracker;
    logic [VTX_W-1:0] corner [MAX_FACES_DEF][3];
    int unsigned      scan_count;
    adjacency_t       pending_adjacency[$];
    int unsigned      mismatches;
    int unsigned      writes_seen;
    int unsigned      queries_checked;

    function void set_face_count(logic [CNT_W-1:0] value);
      scan_count = value;
    endfunction

    function int unsigned pending();
      return pending_adjacency.size();
    endfunction

    function void note_transaction(logic mode, logic [IDX_W-1:0] slot,
                                   logic [VTX_W-1:0] va, logic [VTX_W-1:0] vb,
                                   logic [VTX_W-1:0] vc);
      adjacency_t       res;
      logic [VTX_W-1:0] a, b, c, p, q, r, o1, o2;
      int               limit;
      int               j;
      bit               via_a, via_b;
      if (mode == MODE_WRITE) begin
        corner[slot][0] = va;
        corner[slot][1] = vb;
        corner[slot][2] = vc;
        writes_seen++;
        return;
      end
      a = corner[slot][0];
      b = corner[slot][1];
      c = corner[slot][2];
      res = '0;
      res.face = slot;
      limit = (scan_count > MAX_FACES_DEF) ? MAX_FACES_DEF : scan_count;
      for (j = 0; j < limit; j++) begin
        if (j == slot) continue;
        p = corner[j][0];
        q = corner[j][1];
        r = corner[j][2];
        o1 = '0;
        o2 = '0;
        via_a = 1'b1;
        via_b = 1'b1;
        // the first vertex equal to a is the shared one
        if (p == a) begin
          o1 = q; o2 = r;
        end else if (q == a) begin
          o1 = p; o2 = r;
        end else if (r == a) begin
          o1 = p; o2 = q;
        end else begin
          via_a = 1'b0;
        end
        if (via_a) begin
          if (o1 == b || o2 == b) begin
            res.ab = IDX_W'(j); res.fab = 1'b1;
          end else if (o1 == c || o2 == c) begin
            res.ac = IDX_W'(j); res.fac = 1'b1;
          end
        end else begin
          if (p == b) begin
            o1 = q; o2 = r;
          end else if (q == b) begin
            o1 = p; o2 = r;
          end else if (r == b) begin
            o1 = p; o2 = q;
          end else begin
            via_b = 1'b0;
          end
          if (via_b && (o1 == c || o2 == c)) begin
            res.bc = IDX_W'(j); res.fbc = 1'b1;
          end
        end
      end
      pending_adjacency = {pending_adjacency, res};
    endfunction

    function void compare_field(string name, logic [IDX_W-1:0] want, logic [IDX_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_adjacency(adjacency_t got);
      adjacency_t want;
      if (pending_adjacency.size() == 0) begin
        $error("result for face %0d with no query outstanding", got.face);
        mismatches++;
        return;
      end
      want = pending_adjacency.pop_front();
      queries_checked++;
      compare_field("queried_face", want.face, got.face);
      compare_field("across_ab", want.ab, got.ab);
      compare_field("found_ab", IDX_W'(want.fab), IDX_W'(got.fab));
      compare_field("across_ac", want.ac, got.ac);
      compare_field("found_ac", IDX_W'(want.fac), IDX_W'(got.fac));
      compare_field("across_bc", want.bc, got.bc);
      compare_field("found_bc", IDX_W'(want.fbc), IDX_W'(got.fbc));
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CNT_W-1:0] cfg_wdata_i;
  logic             start_i;
  logic             busy_o;
  logic             mode_i;
  logic [IDX_W-1:0] face_index_i;
  logic [VTX_W-1:0] vertex_a_i;
  logic [VTX_W-1:0] vertex_b_i;
  logic [VTX_W-1:0] vertex_c_i;
  logic             done_o;
  logic [IDX_W-1:0] queried_face_o;
  logic [IDX_W-1:0] across_ab_o;
  logic             found_ab_o;
  logic [IDX_W-1:0] across_ac_o;
  logic             found_ac_o;
  logic [IDX_W-1:0] across_bc_o;
  logic             found_bc_o;

  neighbour_tracker sb;
  bit               slot_written [MAX_FACES_DEF];
  int               written_slots[$];
  bit               sender_idles;
  int               mesh_base;
  int               mesh_span;
  int               random_items;
  int               settings_applied;
  int               quiet_cycles;

  triangle_face_adjacency_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .mode_i         (mode_i),
    .face_index_i   (face_index_i),
    .vertex_a_i     (vertex_a_i),
    .vertex_b_i     (vertex_b_i),
    .vertex_c_i     (vertex_c_i),
    .done_o         (done_o),
    .queried_face_o (queried_face_o),
    .across_ab_o    (across_ab_o),
    .found_ab_o     (found_ab_o),
    .across_ac_o    (across_ac_o),
    .found_ac_o     (found_ac_o),
    .across_bc_o    (across_bc_o),
    .found_bc_o     (found_bc_o)
  );

  always #6 clk_i = ~clk_i;

  // results are checked before the transaction of the same edge is noted
  always @(posedge clk_i) begin : monitor
    adjacency_t seen;
    bit         moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (done_o) begin
        seen = {queried_face_o, across_ab_o, found_ab_o, across_ac_o, found_ac_o,
                across_bc_o, found_bc_o};
        sb.check_adjacency(seen);
        moved = 1'b1;
      end
      if (start_i && !busy_o) begin
        sb.note_transaction(mode_i, face_index_i, vertex_a_i, vertex_b_i, vertex_c_i);
        moved = 1'b1;
      end
      if (cfg_we_i) begin
        sb.set_face_count(cfg_wdata_i);
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  function automatic logic [VTX_W-1:0] mesh_vertex();
    if ($urandom_range(0, 99) < 12) return VTX_W'($urandom);
    return VTX_W'(mesh_base + $urandom_range(0, mesh_span));
  endfunction

  // start_i is left high when the task returns; only idle_gap and drain_block lower it
  task automatic issue(logic mode, int slot, logic [VTX_W-1:0] va, logic [VTX_W-1:0] vb,
                       logic [VTX_W-1:0] vc);
    start_i      <= 1'b1;
    mode_i       <= mode;
    face_index_i <= IDX_W'(slot);
    vertex_a_i   <= va;
    vertex_b_i   <= vb;
    vertex_c_i   <= vc;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic store_face(int slot, logic [VTX_W-1:0] va, logic [VTX_W-1:0] vb,
                            logic [VTX_W-1:0] vc);
    issue(MODE_WRITE, slot, va, vb, vc);
    if (!slot_written[slot]) begin
      slot_written[slot] = 1'b1;
      written_slots = {written_slots, slot};
    end
  endtask

  task automatic ask_face(int slot);
    issue(MODE_QUERY, slot, VTX_W'($urandom), VTX_W'($urandom), VTX_W'($urandom));
  endtask

  task automatic idle_gap();
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic drain_block();
    start_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0 || busy_o);
    repeat (4) @(posedge clk_i);
  endtask

  // every slot the scan will touch gets a triangle before the count is written
  task automatic load_face_count(int count);
    int limit;
    int j;
    limit = (count > MAX_FACES_DEF) ? MAX_FACES_DEF : count;
    for (j = 0; j < limit; j++)
      if (!slot_written[j]) store_face(j, mesh_vertex(), mesh_vertex(), mesh_vertex());
    drain_block();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CNT_W'(count);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    settings_applied++;
  endtask

  task automatic random_item(int count);
    int span;
    int slot;
    span = (count > MAX_FACES_DEF) ? MAX_FACES_DEF : count;
    idle_gap();
    if ($urandom_range(0, 99) < 45) begin
      if (span > 0 && $urandom_range(0, 3) != 0) ask_face($urandom_range(0, span - 1));
      else ask_face(written_slots[$urandom_range(0, written_slots.size() - 1)]);
    end else begin
      if (span > 0 && $urandom_range(0, 9) < 7) slot = $urandom_range(0, span - 1);
      else slot = $urandom_range(0, MAX_FACES_DEF - 1);
      store_face(slot, mesh_vertex(), mesh_vertex(), mesh_vertex());
    end
    random_items++;
  endtask

  initial begin : stimulus
    int count;
    int pick;
    sb = new();
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    start_i      = 1'b0;
    mode_i       = MODE_WRITE;
    face_index_i = '0;
    vertex_a_i   = '0;
    vertex_b_i   = '0;
    vertex_c_i   = '0;
    sender_idles = 1'b0;
    mesh_base    = 0;
    mesh_span    = 7;
    random_items = 0;
    settings_applied = 0;
    quiet_cycles = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // face_count still zero from reset: nothing to scan
    store_face(0, 16'd1, 16'd2, 16'd3);
    ask_face(0);

    // small hand-built mesh around face 0 = (10,20,30)
    store_face(0, 16'd10, 16'd20, 16'd30);
    store_face(1, 16'd20, 16'd10, 16'd99);          // shared a in second place
    store_face(2, 16'd99, 16'd30, 16'd10);          // shared a in third place, edge a-c
    store_face(3, 16'd30, 16'd5, 16'd20);           // no a, edge b-c
    store_face(4, 16'd10, 16'd20, 16'd30);          // duplicate, later a-b wins
    store_face(5, 16'hffff, 16'hffff, 16'hffff);
    store_face(6, 16'd10, 16'd30, 16'd7);           // later a-c wins
    store_face(7, 16'd0, 16'd0, 16'd0);
    load_face_count(8);
    ask_face(0);
    ask_face(5);
    ask_face(7);
    ask_face(4);                                    // own slot is skipped
    store_face(1023, 16'd20, 16'd30, 16'd10);       // queried slot beyond the scan range
    ask_face(1023);
    load_face_count(1);
    ask_face(0);
    ask_face(1);

    // random phases over a spread of scan lengths
    sender_idles = 1'b1;
    while (random_items < 340) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) count = 0;
      else if (pick == 1) count = 1;
      else if (pick == 2) count = 2;
      else if (pick < 7) count = $urandom_range(3, 12);
      else if (pick < 9) count = $urandom_range(13, 40);
      else count = $urandom_range(41, 100);
      pick = $urandom_range(0, 5);
      if (pick == 0) mesh_base = 0;
      else if (pick == 1) mesh_base = 65535 - 12;
      else mesh_base = $urandom_range(0, 65535 - 12);
      mesh_span = $urandom_range(2, 12);
      load_face_count(count);
      repeat ($urandom_range(30, 80)) begin
        random_item(count);
        if ($urandom_range(0, 39) == 0) drain_block();
      end
    end

    // a longer scan over a larger part of the table
    sender_idles = 1'b0;
    mesh_base = $urandom_range(0, 65535 - 6);
    mesh_span = 5;
    count = $urandom_range(101, 128);
    load_face_count(count);
    ask_face(0);
    ask_face(count - 1);
    ask_face($urandom_range(1, count - 2));

    // closing stretch, back to back
    count = $urandom_range(3, 20);
    mesh_base = $urandom_range(0, 65535 - 8);
    mesh_span = 6;
    load_face_count(count);
    repeat (80) random_item(count);

    drain_block();
    $display("testbench: %0d face writes and %0d neighbour queries over %0d face_count settings",
             sb.writes_seen, sb.queries_checked, settings_applied);
    $display("testbench: scans from empty up to about 128 slots, gaps, pauses, back to back");
    if (sb.mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
